// ===== hdl/tcc_pkg.sv =====
// shared constants and types for the triangle circumcenter unit
package tcc_pkg;

  localparam int OFF_BITS = 40;             // offset magnitude clamps at 2^40
  localparam int QW       = OFF_BITS + 1;   // unsigned quotient incl. clamp value
  localparam int OFFW     = OFF_BITS + 2;   // signed offset
  localparam int CSW      = OFFW + 1;       // center sum before clamping
  localparam int OUTW     = 32;
  localparam int DIST_W   = OUTW + 1;
  localparam int SQW      = 2 * DIST_W;
  localparam int ROOTW    = DIST_W;

  localparam int SORT_LAT = 2;
  localparam int GEOM_LAT = 9;
  localparam int DIV_LAT  = OFF_BITS + 1;
  localparam int POST_LAT = 5;
  localparam int SQRT_LAT = ROOTW + 1;

  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } tcc_ctl_t;

endpackage

// ===== hdl/tcc_sort.sv =====
// input register and lexicographic sort of the three points
module tcc_sort #(
  parameter int CW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [3*CW-1:0] p0,
  input  logic [3*CW-1:0] p1,
  input  logic [3*CW-1:0] p2,
  output logic            out_valid,
  output logic [3*CW-1:0] s0,
  output logic [3*CW-1:0] s1,
  output logic [3*CW-1:0] s2,
  output logic [3*CW-1:0] orig
);

  logic            v0;
  logic [3*CW-1:0] r0, r1, r2;
  logic            c01, c02, c12;
  logic [3*CW-1:0] m0, m1, n0, n2;

  // points packed as {x, y, z}
  function automatic logic lt(input logic [3*CW-1:0] p, input logic [3*CW-1:0] q);
    logic signed [CW-1:0] px, py, pz, qx, qy, qz;
    px = p[3*CW-1:2*CW];
    py = p[2*CW-1:CW];
    pz = p[CW-1:0];
    qx = q[3*CW-1:2*CW];
    qy = q[2*CW-1:CW];
    qz = q[CW-1:0];
    return (px < qx) || (px == qx && py < qy) || (px == qx && py == qy && pz < qz);
  endfunction

  always_comb begin
    c01 = lt(r0, r1);
    m0  = c01 ? r1 : r0;
    m1  = c01 ? r0 : r1;
    c02 = lt(m0, r2);
    n0  = c02 ? r2 : m0;
    n2  = c02 ? m0 : r2;
    c12 = lt(m1, n2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0        <= in_valid;
      out_valid <= v0;
    end
  end

  always_ff @(posedge clk) begin
    r0   <= p0;
    r1   <= p1;
    r2   <= p2;
    s0   <= n0;
    s1   <= c12 ? n2 : m1;
    s2   <= c12 ? m1 : n2;
    orig <= r0;
  end

endmodule

// ===== hdl/tcc_geom.sv =====
// edge vectors, cross product, numerators and denominator, nine stages
module tcc_geom #(
  parameter int CW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [3*CW-1:0]   s0,
  input  logic [3*CW-1:0]   s1,
  input  logic [3*CW-1:0]   s2,
  output logic              out_valid,
  output tcc_pkg::tcc_ctl_t ctl,
  output logic [5*CW+6:0]   num_n [3],
  output logic [4*CW+4:0]   den_d
);
  import tcc_pkg::*;

  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int LW   = 2 * CW + 3;
  localparam int CRW  = 2 * CW + 2;
  localparam int DENW = 2 * CRW;
  localparam int TW   = LW + DW;
  localparam int NW   = TW + CRW;
  localparam int TLO  = TW / 2;
  localparam int THI  = TW - TLO;
  localparam int NQW  = NW + 1;

  logic [GEOM_LAT-1:0] vp;

  logic signed [CW-1:0]  pa [3], pb [3], pc [3];
  logic signed [DW-1:0]  ba1 [3], ca1 [3], ba2 [3], ca2 [3], ba3 [3], ca3 [3];
  logic signed [PW-1:0]  sqb2 [3], sqc2 [3], xp2 [6];
  logic signed [LW-1:0]  bal3, cal3;
  logic signed [CRW-1:0] cr3 [3], cr4 [3], cr5 [3];
  logic signed [TW-1:0]  tpa4 [3], tpb4 [3], t5 [3];
  logic signed [DENW-1:0] crsq4 [3];
  logic [DENW-1:0]       den5, den6, den7, den8;
  logic signed [TLO+CRW:0]   pla6 [3], plb6 [3];
  logic signed [THI+CRW-1:0] pha6 [3], phb6 [3];
  logic signed [NW-1:0]  num7 [3];
  logic [NW-1:0]         mag8 [3];
  logic [2:0]            neg8;
  logic                  degen8;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa[k] = s0[(3-k)*CW-1 -: CW];
      pb[k] = s1[(3-k)*CW-1 -: CW];
      pc[k] = s2[(3-k)*CW-1 -: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else begin
      vp <= {vp[GEOM_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vp[GEOM_LAT-1];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ba1[k]  <= DW'(pb[k]) - DW'(pa[k]);
      ca1[k]  <= DW'(pc[k]) - DW'(pa[k]);
      sqb2[k] <= ba1[k] * ba1[k];
      sqc2[k] <= ca1[k] * ca1[k];
      ba2[k]  <= ba1[k];
      ca2[k]  <= ca1[k];
      cr3[k]  <= CRW'(xp2[2*k]) - CRW'(xp2[2*k+1]);
      ba3[k]  <= ba2[k];
      ca3[k]  <= ca2[k];
      tpa4[k] <= bal3 * ca3[k];
      tpb4[k] <= cal3 * ba3[k];
      crsq4[k] <= cr3[k] * cr3[k];
      cr4[k]  <= cr3[k];
      t5[k]   <= tpa4[k] - tpb4[k];
      cr5[k]  <= cr4[k];
      neg8[k] <= num7[k][NW-1];
      mag8[k] <= num7[k][NW-1] ? $unsigned(-num7[k]) : $unsigned(num7[k]);
      num_n[k] <= NQW'(mag8[k]) + NQW'(den8);
    end
    // cross product partials, x then y then z
    xp2[0] <= ba1[1] * ca1[2];
    xp2[1] <= ca1[1] * ba1[2];
    xp2[2] <= ba1[2] * ca1[0];
    xp2[3] <= ca1[2] * ba1[0];
    xp2[4] <= ba1[0] * ca1[1];
    xp2[5] <= ca1[0] * ba1[1];
    bal3   <= LW'(sqb2[0]) + LW'(sqb2[1]) + LW'(sqb2[2]);
    cal3   <= LW'(sqc2[0]) + LW'(sqc2[1]) + LW'(sqc2[2]);
    den5   <= $unsigned(crsq4[0]) + $unsigned(crsq4[1]) + $unsigned(crsq4[2]);
    den6   <= den5;
    den7   <= den6;
    den8   <= den7;
    degen8 <= (den7 == '0);
    den_d  <= {den8, 1'b0};
    ctl.degen <= degen8;
    ctl.neg   <= neg8;
  end

  // num_k = t[k+1]*cr[k+2] - t[k+2]*cr[k+1], t split in low and high halves
  for (genvar k = 0; k < 3; k++) begin : g_num
    localparam int KA = (k + 1) % 3;
    localparam int KB = (k + 2) % 3;
    always_ff @(posedge clk) begin
      pla6[k] <= $signed({1'b0, t5[KA][TLO-1:0]}) * cr5[KB];
      pha6[k] <= $signed(t5[KA][TW-1:TLO]) * cr5[KB];
      plb6[k] <= $signed({1'b0, t5[KB][TLO-1:0]}) * cr5[KA];
      phb6[k] <= $signed(t5[KB][TW-1:TLO]) * cr5[KA];
      num7[k] <= ((NW'(pha6[k]) <<< TLO) + NW'(pla6[k]))
               - ((NW'(phb6[k]) <<< TLO) + NW'(plb6[k]));
    end
  end

endmodule

// ===== hdl/tcc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, clamped quotient
module tcc_div #(
  parameter int NQW = 87,
  parameter int DDW = 69
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [NQW-1:0]         n,
  input  logic [DDW-1:0]         d,
  output logic                   out_valid,
  output logic [tcc_pkg::QW-1:0] q
);
  import tcc_pkg::*;

  localparam int CMPW = (NQW > DDW + OFF_BITS) ? NQW : DDW + OFF_BITS;

  logic [DIV_LAT-1:0] v;
  logic [CMPW-1:0]    r   [DIV_LAT];
  logic [DDW-1:0]     dd  [DIV_LAT];
  logic [QW-1:0]      qq  [DIV_LAT];
  logic               sat [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[DIV_LAT-2:0], in_valid};
    end
  end

  // quotient at or above the clamp value is decided up front
  always_ff @(posedge clk) begin
    r[0]   <= CMPW'(n);
    dd[0]  <= d;
    qq[0]  <= '0;
    sat[0] <= CMPW'(n) >= (CMPW'(d) << OFF_BITS);
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_stage
    localparam int B = OFF_BITS - j;
    logic [CMPW-1:0] sh;
    logic            ge;
    assign sh = CMPW'(dd[j-1]) << B;
    assign ge = r[j-1] >= sh;
    always_ff @(posedge clk) begin
      r[j]   <= ge ? r[j-1] - sh : r[j-1];
      qq[j]  <= qq[j-1] | (ge ? (QW'(1) << B) : QW'(0));
      dd[j]  <= dd[j-1];
      sat[j] <= sat[j-1];
    end
  end

  assign out_valid = v[DIV_LAT-1];
  assign q = sat[DIV_LAT-1] ? (QW'(1) << OFF_BITS) : qq[DIV_LAT-1];

endmodule

// ===== hdl/tcc_sqrt.sv =====
// pipelined floored integer square root, one root bit per stage
module tcc_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [tcc_pkg::SQW-1:0]   sq,
  output logic                      out_valid,
  output logic [tcc_pkg::ROOTW-1:0] root
);
  import tcc_pkg::*;

  localparam int RW = SQW + 2;

  logic [SQRT_LAT-1:0] v;
  logic [RW-1:0]       r  [SQRT_LAT];
  logic [ROOTW-1:0]    rt [SQRT_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[SQRT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    r[0]  <= RW'(sq);
    rt[0] <= '0;
  end

  // r holds sq - root^2; trial term is (root + 2^B)^2 - root^2
  for (genvar j = 1; j < SQRT_LAT; j++) begin : g_stage
    localparam int B = ROOTW - j;
    logic [RW-1:0] t;
    logic          ge;
    assign t  = (RW'(rt[j-1]) << (B + 1)) | (RW'(1) << (2 * B));
    assign ge = r[j-1] >= t;
    always_ff @(posedge clk) begin
      r[j]  <= ge ? r[j-1] - t : r[j-1];
      rt[j] <= rt[j-1] | (ge ? (ROOTW'(1) << B) : ROOTW'(0));
    end
  end

  assign out_valid = v[SQRT_LAT-1];
  assign root      = rt[SQRT_LAT-1];

endmodule

// ===== hdl/triangle_circumcenter_3d_unit.sv =====
// triangle circumcenter unit: sort, geometry, three dividers, center, radius
//
//  channel  handshake        payload
//  in       start / busy     first_*, second_*, third_*  (COORD_WIDTH, signed)
//  out      done (strobe)    center_x/y/z, radius, degenerate, saturated
//
// one word accepted per cycle while busy is low; words pass through the sort,
// geometry, 41-stage quotient dividers, center logic and 34-stage square root.
// busy is high only during reset; synchronous reset empties the pipeline.
// the receiver cannot stall, so no word is ever held back inside.
module triangle_circumcenter_3d_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic signed [COORD_WIDTH-1:0] third_x,
  input  logic signed [COORD_WIDTH-1:0] third_y,
  input  logic signed [COORD_WIDTH-1:0] third_z,
  output logic                          done,
  output logic signed [31:0]            center_x,
  output logic signed [31:0]            center_y,
  output logic signed [31:0]            center_z,
  output logic [31:0]                   radius,
  output logic                          degenerate,
  output logic                          saturated
);
  import tcc_pkg::*;

  localparam int CW        = COORD_WIDTH;
  localparam int NQW       = 5 * CW + 7;
  localparam int DDW       = 4 * CW + 5;
  localparam int SIDE_LAT  = GEOM_LAT + DIV_LAT;
  localparam int TAIL_LAT  = SQRT_LAT + 3;
  localparam int TAIL_W    = 3 * OUTW + 2;
  localparam int TOTAL_LAT = SORT_LAT + GEOM_LAT + DIV_LAT + POST_LAT + SQRT_LAT + 1;
  localparam logic signed [CSW-1:0] CMAX = {{(CSW-OUTW+1){1'b0}}, {(OUTW-1){1'b1}}};
  localparam logic signed [CSW-1:0] CMIN = ~CMAX;

  logic accept;

  logic            sv;
  logic [3*CW-1:0] s0, s1, s2, orig;

  logic            gv;
  tcc_ctl_t        gctl;
  logic [NQW-1:0]  gn [3];
  logic [DDW-1:0]  gd;

  logic [2:0]      dv;
  logic [QW-1:0]   dq [3];

  logic [6*CW-1:0] sd [SIDE_LAT];
  tcc_ctl_t        cd [DIV_LAT];

  logic                    v1, v2, v3, v4, v5;
  logic signed [OFFW-1:0]  off1 [3];
  logic signed [CW-1:0]    sa1 [3], org1 [3], org2 [3];
  logic                    degen1, degen2;
  logic signed [CSW-1:0]   csum [3];
  logic signed [OUTW-1:0]  ctr2 [3];
  logic                    sat2;
  logic signed [DIST_W-1:0] dd3 [3];
  logic signed [SQW-1:0]   dsq4 [3];
  logic [SQW-1:0]          sq5;
  logic [TAIL_W-1:0]       td [TAIL_LAT];

  logic                    qv;
  logic [ROOTW-1:0]        root;

  assign busy   = rst;
  assign accept = start & ~busy;

  tcc_sort #(.CW(CW)) u_sort (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .p0        ({first_x, first_y, first_z}),
    .p1        ({second_x, second_y, second_z}),
    .p2        ({third_x, third_y, third_z}),
    .out_valid (sv),
    .s0        (s0),
    .s1        (s1),
    .s2        (s2),
    .orig      (orig)
  );

  tcc_geom #(.CW(CW)) u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sv),
    .s0        (s0),
    .s1        (s1),
    .s2        (s2),
    .out_valid (gv),
    .ctl       (gctl),
    .num_n     (gn),
    .den_d     (gd)
  );

  for (genvar k = 0; k < 3; k++) begin : g_div
    tcc_div #(.NQW(NQW), .DDW(DDW)) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (gv),
      .n         (gn[k]),
      .d         (gd),
      .out_valid (dv[k]),
      .q         (dq[k])
    );
  end

  // sorted first point and first input point ride alongside the math
  always_ff @(posedge clk) begin
    sd[0] <= {s0, orig};
    for (int i = 1; i < SIDE_LAT; i++) sd[i] <= sd[i-1];
    cd[0] <= gctl;
    for (int i = 1; i < DIV_LAT; i++) cd[i] <= cd[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= dv[0];
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csum[k] = CSW'(sa1[k]) + CSW'(off1[k]);
    end
  end

  always_ff @(posedge clk) begin
    degen1 <= cd[DIV_LAT-1].degen;
    for (int k = 0; k < 3; k++) begin
      if (cd[DIV_LAT-1].degen) begin
        off1[k] <= '0;
      end else if (cd[DIV_LAT-1].neg[k]) begin
        off1[k] <= -$signed({1'b0, dq[k]});
      end else begin
        off1[k] <= $signed({1'b0, dq[k]});
      end
      sa1[k]  <= sd[SIDE_LAT-1][(6-k)*CW-1 -: CW];
      org1[k] <= sd[SIDE_LAT-1][(3-k)*CW-1 -: CW];
      // clamp to 32 bits
      if (csum[k] > CMAX) begin
        ctr2[k] <= OUTW'(CMAX);
      end else if (csum[k] < CMIN) begin
        ctr2[k] <= OUTW'(CMIN);
      end else begin
        ctr2[k] <= OUTW'(csum[k]);
      end
      org2[k] <= org1[k];
      dd3[k]  <= DIST_W'(ctr2[k]) - DIST_W'(org2[k]);
      dsq4[k] <= dd3[k] * dd3[k];
    end
    sat2   <= (csum[0] > CMAX) || (csum[0] < CMIN) || (csum[1] > CMAX) ||
              (csum[1] < CMIN) || (csum[2] > CMAX) || (csum[2] < CMIN);
    degen2 <= degen1;
    sq5    <= $unsigned(dsq4[0]) + $unsigned(dsq4[1]) + $unsigned(dsq4[2]);
    td[0]  <= {ctr2[0], ctr2[1], ctr2[2], degen2, sat2};
    for (int i = 1; i < TAIL_LAT; i++) td[i] <= td[i-1];
  end

  tcc_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .sq        (sq5),
    .out_valid (qv),
    .root      (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= qv;
    end
  end

  always_ff @(posedge clk) begin
    center_x   <= td[TAIL_LAT-1][TAIL_W-1 -: OUTW];
    center_y   <= td[TAIL_LAT-1][TAIL_W-OUTW-1 -: OUTW];
    center_z   <= td[TAIL_LAT-1][TAIL_W-2*OUTW-1 -: OUTW];
    degenerate <= td[TAIL_LAT-1][1];
    radius     <= root[OUTW] ? {OUTW{1'b1}} : root[OUTW-1:0];
    saturated  <= td[TAIL_LAT-1][0] | root[OUTW];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##TOTAL_LAT done)
    else $error("result strobe missing at fixed latency");

  a_degen_nosat: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> !saturated)
    else $error("degenerate result flagged as saturated");

  a_lanes: assert property (@(posedge clk) disable iff (rst)
    (dv[0] == dv[1]) && (dv[1] == dv[2]))
    else $error("divider lanes out of step");

endmodule
